// ===== sv/dual_pid_speed_controller_macros.svh =====
// Assertion macros for the dual PID speed controller.
// Used by the top level; relies on clk_i and rst_ni in the including scope.
`ifndef DUAL_PID_SPEED_CONTROLLER_MACROS_SVH
`define DUAL_PID_SPEED_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
`define DPS_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("dps assertion failed");
`define DPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dps assertion failed");
`else
`define DPS_ASSERT(lbl, expr)
`define DPS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== sv/dps_pkg.sv =====
// Shared types and constants for the dual PID speed controller.
// No dependencies; used by dps_lane, dps_merge and the top level.
`default_nettype none
package dps_pkg;

  localparam int DATA_W       = 16;
  localparam int APB_ADDR_W   = 5;
  localparam int APB_DATA_W   = 32;
  localparam int TICKS_DEFAULT = 40;
  localparam int DRIVE_LIMIT  = 25344;

  localparam logic signed [DATA_W-1:0] GAIN_P_B_RESET = 16'sd512;

  typedef enum logic [2:0] {
    REG_GAIN_P_A   = 3'd0,
    REG_GAIN_I_A   = 3'd1,
    REG_GAIN_D_A   = 3'd2,
    REG_SETPOINT_A = 3'd3,
    REG_GAIN_P_B   = 3'd4,
    REG_GAIN_I_B   = 3'd5,
    REG_GAIN_D_B   = 3'd6,
    REG_SETPOINT_B = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] kp;
    logic signed [DATA_W-1:0] ki;
    logic signed [DATA_W-1:0] kd;
    logic signed [DATA_W-1:0] setpoint;
  } gains_t;

  typedef struct packed {
    logic load;
    logic adv_s2;
    logic adv_s3;
  } lane_ctrl_t;

endpackage
`default_nettype wire

// ===== sv/dps_lane.sv =====
// One PID channel: error/derivative stage, product stage, integral stage.
// Depends on dps_pkg; driven by the shared valid chain in the top level.
`default_nettype none
module dps_lane (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire dps_pkg::gains_t                   cfg_i,
  input  wire logic signed [dps_pkg::DATA_W-1:0] speed_i,
  input  wire dps_pkg::lane_ctrl_t               ctrl_i,
  output logic signed [dps_pkg::DATA_W-1:0]      drive_o
);

  localparam logic signed [33:0] IntLim   = 34'(dps_pkg::DRIVE_LIMIT);
  localparam logic signed [35:0] DriveLim = 36'(dps_pkg::DRIVE_LIMIT);

  logic signed [15:0] kp, ki, kd, sp;
  logic signed [16:0] err_d, err_q, prev_q;
  logic signed [17:0] diff_d, diff_q;
  logic signed [32:0] p_d, p_q, i_d, i_q;
  logic signed [33:0] d_d, d_q;
  logic signed [33:0] isum;
  logic signed [15:0] integ_d, integ_q, integ3_q;
  logic signed [34:0] pd_d, pd_q;
  logic signed [35:0] dsum;

  assign kp = cfg_i.kp;
  assign ki = cfg_i.ki;
  assign kd = cfg_i.kd;
  assign sp = cfg_i.setpoint;

  always_comb begin
    err_d  = 17'(sp) - 17'(speed_i);
    diff_d = 18'(err_d) - 18'(prev_q);
    p_d    = kp * err_q;
    i_d    = ki * err_q;
    d_d    = kd * diff_q;
    isum   = 34'(integ_q) + 34'(i_q);
    if (isum > IntLim) begin
      integ_d = 16'(IntLim);
    end else if (isum < -IntLim) begin
      integ_d = 16'(-IntLim);
    end else begin
      integ_d = isum[15:0];
    end
    pd_d = 35'(p_q) + 35'(d_q);
    dsum = 36'(pd_q) + 36'(integ3_q);
    if (dsum > DriveLim) begin
      drive_o = 16'(DriveLim);
    end else if (dsum < -DriveLim) begin
      drive_o = 16'(-DriveLim);
    end else begin
      drive_o = dsum[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      integ_q <= '0;
    end else begin
      if (ctrl_i.load) begin
        prev_q <= err_d;
      end
      if (ctrl_i.adv_s3) begin
        integ_q <= integ_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      err_q  <= err_d;
      diff_q <= diff_d;
    end
    if (ctrl_i.adv_s2) begin
      p_q <= p_d;
      i_q <= i_d;
      d_q <= d_d;
    end
    if (ctrl_i.adv_s3) begin
      pd_q     <= pd_d;
      integ3_q <= integ_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/dps_merge.sv =====
// Output stage: packs both lane drives into one word and holds it for the sink.
// Depends on dps_pkg.
`default_nettype none
module dps_merge (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              valid_i,
  input  wire logic signed [dps_pkg::DATA_W-1:0] drive_a_i,
  input  wire logic signed [dps_pkg::DATA_W-1:0] drive_b_i,
  output logic                                   ready_o,
  output logic                                   m_valid_o,
  input  wire logic                              m_ready_i,
  output logic [2*dps_pkg::DATA_W-1:0]           m_data_o
);

  logic                          valid_q, valid_d;
  logic [2*dps_pkg::DATA_W-1:0]  data_q;
  logic                          push;

  assign ready_o   = !valid_q || m_ready_i;
  assign push      = valid_i && ready_o;
  assign valid_d   = push || (valid_q && !m_ready_i);
  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      data_q <= {drive_b_i, drive_a_i};
    end
  end

endmodule
`default_nettype wire

// ===== sv/dual_pid_speed_controller.sv =====
// Channel   Dir  Handshake              Word
// s_axis    in   tvalid/tready          speed_a[15:0], speed_b[31:16]
// m_axis    out  tvalid/tready          drive_a[15:0], drive_b[31:16]
// apb       in   psel/penable/pready    8 x 16-bit registers at 4*i
//
// One tick word is taken per cycle while s_axis_tready is high; every
// TICKS_PER_UPDATE-th tick is an update. An update passes the error stage,
// multiplier stage, integral clamp stage, then drive clamp into the output register.
// Both channels run in parallel lanes; the integral register closes the only loop.
// Each stage holds when the one after it is full and stalled; reset clears the tick
// count, error history, integrals and valid flags and loads the register reset values.
`default_nettype none
`include "dual_pid_speed_controller_macros.svh"
module dual_pid_speed_controller #(
  parameter int TICKS_PER_UPDATE = dps_pkg::TICKS_DEFAULT
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [2*dps_pkg::DATA_W-1:0]       s_axis_tdata,  // speed_a, speed_b
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [2*dps_pkg::DATA_W-1:0]            m_axis_tdata,  // drive_a, drive_b
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [dps_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [dps_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [dps_pkg::APB_DATA_W-1:0]          prdata,
  output logic                                    pready
);

  localparam int TickW = $clog2(TICKS_PER_UPDATE + 1);
  localparam logic [TickW-1:0] TickLast = TickW'(TICKS_PER_UPDATE - 1);

  dps_pkg::gains_t     cfg_a_q, cfg_b_q;
  dps_pkg::cfg_reg_e   reg_sel;
  logic [15:0]         rd_val;
  logic                cfg_we;

  logic [TickW-1:0]    tick_q, tick_d;
  logic                v1_q, v2_q, v3_q;
  logic                rdy1, rdy2, rdy3, merge_rdy;
  logic                accept, is_update;
  dps_pkg::lane_ctrl_t ctrl;
  logic signed [15:0]  drive_a, drive_b;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_sel = dps_pkg::cfg_reg_e'(paddr[4:2]);

  always_comb begin
    case (reg_sel)
      dps_pkg::REG_GAIN_P_A:   rd_val = cfg_a_q.kp;
      dps_pkg::REG_GAIN_I_A:   rd_val = cfg_a_q.ki;
      dps_pkg::REG_GAIN_D_A:   rd_val = cfg_a_q.kd;
      dps_pkg::REG_SETPOINT_A: rd_val = cfg_a_q.setpoint;
      dps_pkg::REG_GAIN_P_B:   rd_val = cfg_b_q.kp;
      dps_pkg::REG_GAIN_I_B:   rd_val = cfg_b_q.ki;
      dps_pkg::REG_GAIN_D_B:   rd_val = cfg_b_q.kd;
      dps_pkg::REG_SETPOINT_B: rd_val = cfg_b_q.setpoint;
      default:                 rd_val = '0;
    endcase
    prdata = {{(dps_pkg::APB_DATA_W-16){rd_val[15]}}, rd_val};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_a_q <= '0;
      cfg_b_q <= '{kp: dps_pkg::GAIN_P_B_RESET, ki: '0, kd: '0, setpoint: '0};
    end else if (cfg_we) begin
      case (reg_sel)
        dps_pkg::REG_GAIN_P_A:   cfg_a_q.kp       <= pwdata[15:0];
        dps_pkg::REG_GAIN_I_A:   cfg_a_q.ki       <= pwdata[15:0];
        dps_pkg::REG_GAIN_D_A:   cfg_a_q.kd       <= pwdata[15:0];
        dps_pkg::REG_SETPOINT_A: cfg_a_q.setpoint <= pwdata[15:0];
        dps_pkg::REG_GAIN_P_B:   cfg_b_q.kp       <= pwdata[15:0];
        dps_pkg::REG_GAIN_I_B:   cfg_b_q.ki       <= pwdata[15:0];
        dps_pkg::REG_GAIN_D_B:   cfg_b_q.kd       <= pwdata[15:0];
        dps_pkg::REG_SETPOINT_B: cfg_b_q.setpoint <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  assign rdy3          = !v3_q || merge_rdy;
  assign rdy2          = !v2_q || rdy3;
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_update     = (tick_q == TickLast);
  assign ctrl.load     = accept && is_update;
  assign ctrl.adv_s2   = v1_q && rdy2;
  assign ctrl.adv_s3   = v2_q && rdy3;
  assign tick_d        = is_update ? '0 : tick_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
    end else begin
      if (accept) begin
        tick_q <= tick_d;
      end
      v1_q <= ctrl.load   || (v1_q && !ctrl.adv_s2);
      v2_q <= ctrl.adv_s2 || (v2_q && !ctrl.adv_s3);
      v3_q <= ctrl.adv_s3 || (v3_q && !merge_rdy);
    end
  end

  dps_lane u_lane_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_a_q),
    .speed_i (s_axis_tdata[15:0]),
    .ctrl_i  (ctrl),
    .drive_o (drive_a)
  );

  dps_lane u_lane_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_b_q),
    .speed_i (s_axis_tdata[31:16]),
    .ctrl_i  (ctrl),
    .drive_o (drive_b)
  );

  dps_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (v3_q),
    .drive_a_i (drive_a),
    .drive_b_i (drive_b),
    .ready_o   (merge_rdy),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata)
  );

  `DPS_ASSERT(a_tick_bound, tick_q <= TickLast)
  `DPS_ASSERT_NEXT(a_update_enters, ctrl.load, v1_q)
  `DPS_ASSERT_NEXT(a_s3_holds, v3_q && !merge_rdy, v3_q && m_axis_tvalid)

endmodule
`default_nettype wire
